// ----- sv/sst_pkg.sv -----
// sst_pkg: shared types and constants for the sorted set table.
// Used by sst_ctrl, sst_datapath and sorted_set_table; depends on nothing.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned INDEX_W         = 5;
  localparam int unsigned COUNT_W         = 6;
  localparam int unsigned ACTION_W        = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned S_TDATA_W       = 40;
  localparam int unsigned M_TDATA_W       = 40;
  localparam int unsigned TABLE_DEPTH_DEF = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_READ   = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH,
    S_SRCH_CMP,
    S_INS_CHK,
    S_SHIFT,
    S_SHIFT_WR,
    S_INS_WR,
    S_RD_ISSUE,
    S_REM,
    S_REM_WR,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC,
    PTR_COUNT,
    PTR_INDEX
  } ptr_op_e;

  typedef enum logic [1:0] {
    RD_PTR,
    RD_PTR_M1,
    RD_PTR_P1
  } rd_sel_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    ptr_op_e ptr_op;
    logic    pos_load;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    logic    wr_rdata;   // 1: write read-back word, 0: write item value
    cnt_op_e cnt_op;
    logic    st_load;
    status_e st;
    logic    res_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    ptr_lt_cnt;
    logic    ptr1_lt_cnt;
    logic    ptr_gt_pos;
    logic    idx_ge_cnt;
    logic    full;
    logic    rd_lt;
    logic    rd_eq;
    logic    out_busy;
  } stat_t;

endpackage

// ----- sv/sst_ctrl.sv -----
// sst_ctrl: sequencer for insert, read and remove on the sorted table.
// Depends on sst_pkg; drives sst_datapath through cmd_t, watches stat_t.
`timescale 1ns / 1ps

module sst_ctrl
  import sst_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.action)
          ACT_INSERT: state_d = S_SRCH;
          ACT_READ:   state_d = stat_i.idx_ge_cnt ? S_DONE : S_RD_ISSUE;
          ACT_REMOVE: state_d = stat_i.idx_ge_cnt ? S_DONE : S_REM;
          default:    state_d = S_DONE;
        endcase
      end
      S_SRCH: begin
        state_d = stat_i.ptr_lt_cnt ? S_SRCH_CMP : S_INS_CHK;
      end
      S_SRCH_CMP: begin
        if (stat_i.rd_lt) begin
          state_d = S_SRCH;
        end else if (stat_i.rd_eq) begin
          state_d = S_DONE;
        end else begin
          state_d = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        state_d = stat_i.full ? S_DONE : S_SHIFT;
      end
      S_SHIFT: begin
        state_d = stat_i.ptr_gt_pos ? S_SHIFT_WR : S_INS_WR;
      end
      S_SHIFT_WR: state_d = S_SHIFT;
      S_INS_WR:   state_d = S_DONE;
      S_RD_ISSUE: state_d = S_DONE;
      S_REM: begin
        state_d = stat_i.ptr1_lt_cnt ? S_REM_WR : S_DONE;
      end
      S_REM_WR: state_d = S_REM;
      S_DONE: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.ptr_op = PTR_HOLD;
    cmd_o.rd_sel = RD_PTR;
    cmd_o.cnt_op = CNT_HOLD;
    cmd_o.st     = ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_DISPATCH: begin
        case (stat_i.action)
          ACT_INSERT: cmd_o.ptr_op = PTR_ZERO;
          ACT_READ, ACT_REMOVE: begin
            if (stat_i.idx_ge_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st      = ST_RANGE;
            end else begin
              cmd_o.ptr_op = PTR_INDEX;
            end
          end
          default: begin
            cmd_o.st_load = 1'b1;
            cmd_o.st      = ST_RANGE;
          end
        endcase
      end
      S_SRCH: begin
        cmd_o.rd_en  = stat_i.ptr_lt_cnt;
        cmd_o.rd_sel = RD_PTR;
      end
      S_SRCH_CMP: begin
        if (stat_i.rd_lt) begin
          cmd_o.ptr_op = PTR_INC;
        end else if (stat_i.rd_eq) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_DUP;
        end
      end
      S_INS_CHK: begin
        if (stat_i.full) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_FULL;
        end else begin
          cmd_o.pos_load = 1'b1;
          cmd_o.ptr_op   = PTR_COUNT;
        end
      end
      S_SHIFT: begin
        cmd_o.rd_en  = stat_i.ptr_gt_pos;
        cmd_o.rd_sel = RD_PTR_M1;
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_rdata = 1'b1;
        cmd_o.ptr_op   = PTR_DEC;
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.cnt_op  = CNT_INC;
        cmd_o.st_load = 1'b1;
        cmd_o.st      = ST_OK;
      end
      S_RD_ISSUE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_PTR;
        cmd_o.st_load = 1'b1;
        cmd_o.st      = ST_OK;
      end
      S_REM: begin
        if (stat_i.ptr1_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PTR_P1;
        end else begin
          cmd_o.cnt_op  = CNT_DEC;
          cmd_o.st_load = 1'b1;
          cmd_o.st      = ST_OK;
        end
      end
      S_REM_WR: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_rdata = 1'b1;
        cmd_o.ptr_op   = PTR_INC;
      end
      S_DONE: begin
        cmd_o.res_load = !stat_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/sst_datapath.sv -----
// sst_datapath: entry memory, count, pointers, compare and result register.
// Depends on sst_pkg; commanded by sst_ctrl.
`timescale 1ns / 1ps

module sst_datapath
  import sst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [ACTION_W-1:0] in_action_i,
  input  logic [DATA_W-1:0]   in_value_i,
  input  logic [INDEX_W-1:0]  in_index_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [DATA_W-1:0]   out_read_value_o,
  output logic [COUNT_W-1:0]  out_entry_count_o,
  output logic [STATUS_W-1:0] out_status_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int unsigned EW   = (CW > COUNT_W) ? CW : COUNT_W;

  // item registers
  action_e                   action_q;
  logic signed [DATA_W-1:0]  value_q;
  logic [INDEX_W-1:0]        index_q;

  logic [CW-1:0]     count_q, ptr_q, pos_q;
  status_e           st_q;
  logic [DATA_W-1:0] mem_q [TABLE_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  logic                out_valid_q;
  logic [DATA_W-1:0]   res_value_q;
  logic [COUNT_W-1:0]  res_count_q;
  status_e             res_status_q;

  logic [CMPW-1:0] idx_ext;
  logic [EW-1:0]   cnt_ext;
  logic [CW-1:0]   ptr_m1, ptr_p1, rd_ptr;
  logic [CW:0]     ptr_p1_wide;
  logic            full;
  logic            out_busy;

  assign idx_ext     = CMPW'(index_q);
  assign cnt_ext     = EW'(count_q);
  assign ptr_m1      = ptr_q - CW'(1);
  assign ptr_p1      = ptr_q + CW'(1);
  assign ptr_p1_wide = {1'b0, ptr_q} + (CW + 1)'(1);
  assign full        = (count_q == CW'(TABLE_DEPTH));
  assign out_busy    = out_valid_q && !out_ready_i;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PTR_M1: rd_ptr = ptr_m1;
      RD_PTR_P1: rd_ptr = ptr_p1;
      default:   rd_ptr = ptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_e'(in_action_i);
      value_q  <= in_value_i;
      index_q  <= in_index_i;
    end
    if (cmd_i.st_load) st_q <= cmd_i.st;
    if (cmd_i.pos_load) pos_q <= ptr_q;
    case (cmd_i.ptr_op)
      PTR_ZERO:  ptr_q <= '0;
      PTR_INC:   ptr_q <= ptr_p1;
      PTR_DEC:   ptr_q <= ptr_m1;
      PTR_COUNT: ptr_q <= count_q;
      PTR_INDEX: ptr_q <= idx_ext[CW-1:0];
      default:   ;
    endcase
  end

  // entry memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= cmd_i.wr_rdata ? rdata_q : value_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case (cmd_i.cnt_op)
        CNT_INC: count_q <= count_q + CW'(1);
        CNT_DEC: count_q <= count_q - CW'(1);
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_value_q  <= (st_q == ST_OK && action_q == ACT_READ) ? rdata_q : '0;
      res_count_q  <= cnt_ext[COUNT_W-1:0];
      res_status_q <= st_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_read_value_o  = res_value_q;
  assign out_entry_count_o = res_count_q;
  assign out_status_o      = res_status_q;

  assign stat_o.action      = action_q;
  assign stat_o.ptr_lt_cnt  = (ptr_q < count_q);
  assign stat_o.ptr1_lt_cnt = (ptr_p1_wide < {1'b0, count_q});
  assign stat_o.ptr_gt_pos  = (ptr_q > pos_q);
  assign stat_o.idx_ge_cnt  = (idx_ext >= CMPW'(count_q));
  assign stat_o.full        = full;
  assign stat_o.rd_lt       = ($signed(rdata_q) < value_q);
  assign stat_o.rd_eq       = ($signed(rdata_q) == value_q);
  assign stat_o.out_busy    = out_busy;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_inc_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_INC |-> !full)
    else $error("insert into full table");

  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cnt_op == CNT_DEC |-> count_q != '0)
    else $error("remove from empty table");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |-> ptr_q < CW'(TABLE_DEPTH))
    else $error("write address beyond table depth");

  a_res_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !out_busy ##1 out_valid_q)
    else $error("result loaded over a pending word");

endmodule

// ----- sv/sorted_set_table.sv -----
// sorted_set_table: top level of a sorted table of distinct signed 32-bit values.
// Time from accept to result valid grows with the entry walk: insert searches upward, a read then
// a compare per entry, then shifts entries up, a read then a write per entry; remove shifts the
// entries above the index down, a read then a write each. Reads and range errors walk no entries.
// One word in flight; the next is accepted the cycle after the result loads, even while it
// waits. Reset (async, low) empties table count and result.
`timescale 1ns / 1ps

module sorted_set_table
  import sst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] value, [36:32] index, [39:37] zero
  input  logic [ACTION_W-1:0]  s_axis_tuser,  // [1:0] action
  // result channel
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [31:0] read_value, [37:32] entry_count,
                                              // [39:38] zero
  output logic [STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

  cmd_t  cmd;
  stat_t stat;

  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] entry_count;

  // Controller walks the table: search upward for the insert slot, then shift
  // entries up from the top; remove shifts entries down from the index.
  sst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sst_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .in_action_i       (s_axis_tuser),
    .in_value_i        (s_axis_tdata[DATA_W-1:0]),
    .in_index_i        (s_axis_tdata[DATA_W+INDEX_W-1:DATA_W]),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_read_value_o  (read_value),
    .out_entry_count_o (entry_count),
    .out_status_o      (m_axis_tuser)
  );

  // pack result word, zero fill to byte boundary
  assign m_axis_tdata = {(M_TDATA_W - DATA_W - COUNT_W)'(0), entry_count, read_value};

endmodule

// ----- dv/sst_answer_checker.sv -----
// sst_answer_checker: watches both stream channels of sorted_set_table, keeps a shadow
// copy of the table and compares each result word field by field. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_answer_checker
  import sst_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [ACTION_W-1:0]  s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic [STATUS_W-1:0]  m_tuser_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] entry_count;
    status_e            status;
  } answer_t;

  // shadow of the table; slots at or above shadow_count are don't-care
  int      shadow_vals [TABLE_DEPTH];
  int      shadow_count = 0;
  answer_t answers_due[$];
  int      mismatches = 0;
  int      due_n = 0;
  int      word_no = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = due_n;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch on result %0d: %s", $time, word_no, msg);
  endtask

  // applies one request word to the shadow table, returns the answer it must give
  function automatic answer_t shadow_apply(input logic [ACTION_W-1:0] act,
                                           input logic [DATA_W-1:0] raw_val,
                                           input logic [INDEX_W-1:0] idx);
    answer_t ans;
    int      val;
    int      pos;
    int      k;
    ans = '0;
    val = int'(signed'(raw_val));
    case (act)
      ACT_INSERT: begin
        pos = 0;
        while (pos < shadow_count && shadow_vals[pos] < val) pos++;
        // equal value wins over full table
        if (pos < shadow_count && shadow_vals[pos] == val) begin
          ans.status = ST_DUP;
        end else if (shadow_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_vals[k] = shadow_vals[k-1];
          shadow_vals[pos] = val;
          shadow_count++;
          ans.status = ST_OK;
        end
      end
      ACT_READ, ACT_REMOVE: begin
        if (int'(idx) >= shadow_count) begin
          ans.status = ST_RANGE;
        end else begin
          ans.status = ST_OK;
          if (act == ACT_READ) begin
            ans.read_value = shadow_vals[idx];
          end else begin
            for (k = int'(idx); k + 1 < shadow_count; k++) shadow_vals[k] = shadow_vals[k+1];
            shadow_count--;
          end
        end
      end
      default: ans.status = ST_RANGE;  // unused action code
    endcase
    ans.entry_count = shadow_count[COUNT_W-1:0];
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      // result first: a word accepted this edge cannot be answered at the same edge
      if (m_tvalid_i && m_tready_i) begin
        word_no++;
        if (answers_due.size() == 0) begin
          report_mismatch("result word with no request outstanding");
        end else begin
          want = answers_due.pop_front();
          if (m_tdata_i[31:0] !== want.read_value)
            report_mismatch($sformatf("read_value got %0d want %0d",
                                      $signed(m_tdata_i[31:0]), $signed(want.read_value)));
          if (m_tdata_i[37:32] !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      m_tdata_i[37:32], want.entry_count));
          if (m_tuser_i !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", m_tuser_i, want.status));
        end
      end
      if (s_tvalid_i && s_tready_i)
        answers_due.push_back(shadow_apply(s_tuser_i, s_tdata_i[31:0], s_tdata_i[36:32]));
      due_n = answers_due.size();
    end
  end

endmodule

// ----- dv/tb_sorted_set_table.sv -----
// tb_sorted_set_table: stimulus and verdict for sorted_set_table; directed corner words,
// then random fill / drain / mixed episodes under four idling phases. Needs sst_pkg, sst_answer_checker.
`timescale 1ns / 1ps

module tb_sorted_set_table;
  import sst_pkg::*;

  // code 3 is not an action; the block must answer it as out of range
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0]   VAL_MIN    = 32'h8000_0000;
  localparam logic [DATA_W-1:0]   VAL_MAX    = 32'h7FFF_FFFF;
  localparam int                  PHASE_WORDS = 488;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [ACTION_W-1:0]  s_tuser = ACT_INSERT;
  logic                 m_axis_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]  m_axis_tuser;

  int fail_count;
  int pending;
  // idle percentages of the current phase, sender side and receiver side
  int send_gap_pct = 0;
  int hold_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_set_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  sst_answer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver side: drop tready at random per the phase's stall rate
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= hold_pct);
  end

  // one request word; called right after a rising edge, returns right after the
  // edge that accepted it. tvalid stays high when the next word follows at once.
  task automatic push_word(input logic [ACTION_W-1:0] act, input logic [DATA_W-1:0] val,
                           input logic [INDEX_W-1:0] idx);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {3'b000, idx, val};  // [31:0] value, [36:32] index
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mix of a small pool (forces duplicates), the extremes, and full-range values
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return DATA_W'($urandom_range(80) - 40);
    if (r < 50) begin
      case ($urandom_range(5))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return VAL_MIN + 1;
        3: return VAL_MAX - 1;
        4: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  // random episodes: fill pushes the table to full and past it, drain removes
  // mostly low indexes so the table really empties, mixed is everything at once
  task automatic run_episodes(input int words, input bit start_with_fill);
    int sent;
    int mode;
    int len;
    int i;
    int r;
    logic [ACTION_W-1:0] act;
    logic [INDEX_W-1:0]  idx;
    sent = 0;
    mode = start_with_fill ? 0 : $urandom_range(2);
    while (sent < words) begin
      len = (mode == 0) ? $urandom_range(45, 70) : $urandom_range(20, 50);
      for (i = 0; i < len && sent < words; i++) begin
        r   = $urandom_range(99);
        idx = INDEX_W'($urandom_range(31));
        case (mode)
          0: act = (r < 90) ? ACT_INSERT : ACT_READ;
          1: begin
            if (r < 75) begin
              act = ACT_REMOVE;
              if ($urandom_range(99) < 60) idx = INDEX_W'($urandom_range(3));
            end else if (r < 92) begin
              act = ACT_READ;
            end else begin
              act = ACT_INSERT;
            end
          end
          default: begin
            if (r < 40)      act = ACT_INSERT;
            else if (r < 70) act = ACT_READ;
            else if (r < 95) act = ACT_REMOVE;
            else             act = ACT_UNUSED;
          end
        endcase
        push_word(act, pick_value(), idx);
        sent++;
      end
      mode = $urandom_range(2);
    end
  endtask

  initial begin
    int ph;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: empty table, unused code, extremes at head and tail,
    // duplicates at both ends, reads at head, tail, beyond, removes at head, middle, tail, beyond
    push_word(ACT_READ,   '0, 5'd0);
    push_word(ACT_REMOVE, '0, 5'd0);
    push_word(ACT_UNUSED, '1, 5'd31);
    push_word(ACT_INSERT, '0, 5'd0);
    push_word(ACT_INSERT, VAL_MIN, 5'd31);
    push_word(ACT_INSERT, VAL_MAX, 5'd0);
    push_word(ACT_INSERT, VAL_MIN, 5'd0);
    push_word(ACT_INSERT, VAL_MAX, 5'd0);
    push_word(ACT_INSERT, '1, 5'd0);
    push_word(ACT_INSERT, 32'd1, 5'd0);
    push_word(ACT_READ,   '1, 5'd0);
    push_word(ACT_READ,   '0, 5'd4);
    push_word(ACT_READ,   '0, 5'd5);
    push_word(ACT_READ,   '0, 5'd31);
    push_word(ACT_REMOVE, '0, 5'd2);
    push_word(ACT_REMOVE, '0, 5'd0);
    push_word(ACT_REMOVE, '0, 5'd2);
    push_word(ACT_REMOVE, '0, 5'd31);
    push_word(ACT_UNUSED, 32'h5A5A_A5A5, 5'd0);
    push_word(ACT_READ,   '0, 5'd0);

    // idling phases: none, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_gap_pct = 0;  hold_pct = 0;  end
        1: begin send_gap_pct = 87; hold_pct = 0;  end
        2: begin send_gap_pct = 0;  hold_pct = 87; end
        default: begin send_gap_pct = 23; hold_pct = 23; end
      endcase
      run_episodes(PHASE_WORDS, ph == 0);
    end
    s_tvalid <= 1'b0;

    // one edge so the checker has logged the last request, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- sorted_set_table.f -----
sv/sst_pkg.sv
sv/sst_ctrl.sv
sv/sst_datapath.sv
sv/sorted_set_table.sv
dv/sst_answer_checker.sv
dv/tb_sorted_set_table.sv
